@@ rtl/assert_macros.svh @@
// Assertion macros shared by the tree traversal RTL.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/cttrav_pkg.sv @@
// Types and constants for the complete binary tree traversal core.
// Used by cttrav_ctrl, cttrav_dp and the top level.
package cttrav_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int RES_LIMIT     = 16;
  localparam int CHAR_W        = 8;
  localparam int POS_W         = 4;
  localparam int ORDER_W       = 2;

  typedef enum logic [ORDER_W-1:0] {
    ORD_IN   = 2'd0,
    ORD_PRE  = 2'd1,
    ORD_POST = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    PH_LEFT  = 2'd0,
    PH_RIGHT = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef enum logic {
    ST_LOAD = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic walk_init;
    logic walk_step;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic stack_empty;
  } dp_sts_t;

endpackage

@@ rtl/cttrav_ctrl.sv @@
// Controller state machine: load phase and traversal walk.
// Depends on cttrav_pkg; drives cttrav_dp through ctl_cmd_t.
`include "assert_macros.svh"

module cttrav_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last_item,
  input  cttrav_pkg::dp_sts_t sts,
  output cttrav_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import cttrav_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (start && last_item) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.stack_empty) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state)
      ST_LOAD: begin
        cmd.load      = start;
        cmd.walk_init = start && last_item;
      end
      ST_WALK: begin
        busy          = 1'b1;
        cmd.walk_step = !sts.stack_empty;
        // stack drained: release the held final result
        cmd.flush     = sts.stack_empty;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  `ASSERT_NEXT(a_last_enters_walk, start && !busy && last_item, state == ST_WALK)

endmodule

@@ rtl/cttrav_dp.sv @@
// Datapath: node store, load count, walk stack and result registers.
// Depends on cttrav_pkg; commanded by cttrav_ctrl.
`include "assert_macros.svh"

module cttrav_dp #(
  parameter int MAX_NODES = cttrav_pkg::MAX_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cttrav_pkg::ctl_cmd_t                cmd,
  output cttrav_pkg::dp_sts_t                 sts,
  input  logic                                cfg_write,
  input  logic [cttrav_pkg::ORDER_W-1:0]      cfg_wdata,
  input  logic [cttrav_pkg::CHAR_W-1:0]       node_char,
  output logic                                strobe,
  output logic [cttrav_pkg::CHAR_W-1:0]       out_char,
  output logic [cttrav_pkg::POS_W-1:0]        node_position,
  output logic                                last_out
);
  import cttrav_pkg::*;

  localparam int NODES  = (MAX_NODES > RES_LIMIT) ? RES_LIMIT : MAX_NODES;
  localparam int IDXW   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW     = $clog2(NODES + 1);
  localparam int SDEPTH = $clog2(NODES + 1);
  localparam int DW     = $clog2(SDEPTH + 1);
  localparam int SIW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int CMPW   = POS_W + 2;

  logic [CHAR_W-1:0]  store [NODES];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      tree_size;
  logic [ORDER_W-1:0] order;

  logic [POS_W-1:0]   stack_pos   [SDEPTH];
  phase_t             stack_phase [SDEPTH];
  logic [DW-1:0]      depth;

  logic               pend_valid;
  logic [CHAR_W-1:0]  pend_char;
  logic [POS_W-1:0]   pend_pos;

  logic [SIW-1:0]     top_idx;
  logic [SIW-1:0]     push_idx;
  logic [POS_W-1:0]   top_pos;
  phase_t             top_ph;
  logic [CMPW-1:0]    left_pos;
  logic [CMPW-1:0]    right_pos;
  logic [CMPW-1:0]    size_ext;
  logic               emit;
  order_t             mode;

  assign count_next = (count < CW'(NODES)) ? count + CW'(1) : count;

  assign top_idx   = SIW'(depth - DW'(1));
  assign push_idx  = SIW'(depth);
  assign top_pos   = stack_pos[top_idx];
  assign top_ph    = stack_phase[top_idx];
  assign left_pos  = {1'b0, top_pos, 1'b1};
  assign right_pos = {1'b0, top_pos, 1'b0} + CMPW'(2);
  assign size_ext  = CMPW'(tree_size);

  assign sts.stack_empty = (depth == '0);

  // unused code three walks as inorder
  always_comb begin
    case (order)
      ORD_PRE:  mode = ORD_PRE;
      ORD_POST: mode = ORD_POST;
      default:  mode = ORD_IN;
    endcase
  end

  always_comb begin
    case (top_ph)
      PH_LEFT:  emit = (mode == ORD_PRE);
      PH_RIGHT: emit = (mode == ORD_IN);
      default:  emit = (mode == ORD_POST);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (count < CW'(NODES))) begin
      store[count[IDXW-1:0]] <= node_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORD_IN;
    end else if (cfg_write) begin
      order <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      tree_size <= '0;
    end else if (cmd.walk_init) begin
      tree_size <= count_next;
      count     <= '0;
    end else if (cmd.load) begin
      count <= count_next;
    end
  end

  // walk stack: one visit of the top entry per step
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.walk_init) begin
      depth          <= (count_next != '0) ? DW'(1) : '0;
      stack_pos[0]   <= '0;
      stack_phase[0] <= PH_LEFT;
    end else if (cmd.walk_step) begin
      case (top_ph)
        PH_LEFT: begin
          stack_phase[top_idx] <= PH_RIGHT;
          if (left_pos < size_ext) begin
            stack_pos[push_idx]   <= left_pos[POS_W-1:0];
            stack_phase[push_idx] <= PH_LEFT;
            depth                 <= depth + DW'(1);
          end
        end
        PH_RIGHT: begin
          stack_phase[top_idx] <= PH_DONE;
          if (right_pos < size_ext) begin
            stack_pos[push_idx]   <= right_pos[POS_W-1:0];
            stack_phase[push_idx] <= PH_LEFT;
            depth                 <= depth + DW'(1);
          end
        end
        default: begin
          depth <= depth - DW'(1);
        end
      endcase
    end
  end

  // hold each visited node one emit back so the final one can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.walk_init) begin
        pend_valid <= 1'b0;
      end else if (cmd.walk_step && emit) begin
        pend_valid <= 1'b1;
        strobe     <= pend_valid;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
        strobe     <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && emit) begin
      pend_char     <= store[top_pos[IDXW-1:0]];
      pend_pos      <= top_pos;
      out_char      <= pend_char;
      node_position <= pend_pos;
      last_out      <= 1'b0;
    end else if (cmd.flush) begin
      out_char      <= pend_char;
      node_position <= pend_pos;
      last_out      <= 1'b1;
    end
  end

  `ASSERT_IMPL(a_depth_bound, 1'b1, depth <= DW'(SDEPTH))
  `ASSERT_IMPL(a_step_nonempty, cmd.walk_step, depth != '0)
  `ASSERT_NEXT(a_flush_last, cmd.flush && pend_valid, strobe && last_out)

endmodule

@@ rtl/complete_tree_traversal_order_core.sv @@
// Top level of the complete binary tree traversal core.
// Depends on cttrav_pkg, cttrav_ctrl and cttrav_dp.
//
//   channel   handshake            payload
//   input     start, busy          node_char, last_item
//   result    strobe               out_char, node_position, last_out
//   config    cfg_write            cfg_wdata (traversal order)
//
// Load takes one byte per cycle while busy is low; a byte past the store
// size is dropped. The item flagged last starts the walk: busy rises and
// the walk stack visits each node three times, one visit per cycle.
// Results come at most one per cycle, one strobe each; the last one
// carries last_out. Reset clears the load count, walk stack and order
// register; stored bytes are not cleared. Results cannot be stalled.
module complete_tree_traversal_order_core #(
  parameter int MAX_NODES = cttrav_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [cttrav_pkg::CHAR_W-1:0]   node_char,
  input  logic                            last_item,
  input  logic                            cfg_write,
  input  logic [cttrav_pkg::ORDER_W-1:0]  cfg_wdata,
  output logic                            strobe,
  output logic [cttrav_pkg::CHAR_W-1:0]   out_char,
  output logic [cttrav_pkg::POS_W-1:0]    node_position,
  output logic                            last_out
);
  import cttrav_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  cttrav_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  cttrav_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_write     (cfg_write),
    .cfg_wdata     (cfg_wdata),
    .node_char     (node_char),
    .strobe        (strobe),
    .out_char      (out_char),
    .node_position (node_position),
    .last_out      (last_out)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for complete_tree_traversal_order_core: loads trees, walks them in all orders.
// Predicts every visit from its own copy of the node store and order register.
// Depends on cttrav_pkg and the core RTL only.
module tb_top;
  import cttrav_pkg::*;

  localparam int STORE_SIZE = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 380;
  localparam logic [ORDER_W-1:0] ORD_SPARE = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    logic              last;
  } visit_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CHAR_W-1:0]   node_char;
  logic                last_item;
  logic                cfg_write;
  logic [ORDER_W-1:0]  cfg_wdata;
  logic                strobe;
  logic [CHAR_W-1:0]   out_char;
  logic [POS_W-1:0]    node_position;
  logic                last_out;

  complete_tree_traversal_order_core uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .node_char     (node_char),
    .last_item     (last_item),
    .cfg_write     (cfg_write),
    .cfg_wdata     (cfg_wdata),
    .strobe        (strobe),
    .out_char      (out_char),
    .node_position (node_position),
    .last_out      (last_out)
  );

  // Shadow of the core: loaded bytes, load count and order register.
  logic [CHAR_W-1:0]  shadow_store [STORE_SIZE];
  int                 shadow_count;
  logic [ORDER_W-1:0] shadow_order;
  visit_t             pending_visits[$];

  int err_count;
  int items_sent;
  int trees_sent;
  int visits_seen;
  int quiet_cycles;
  bit gaps_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic visit_t make_visit(input int pos);
    visit_t v;
    v.ch   = shadow_store[pos];
    v.pos  = pos[POS_W-1:0];
    v.last = 1'b0;
    return v;
  endfunction

  // Walk the shadow tree with an explicit stack, three visits per node.
  task automatic predict_walk();
    logic [POS_W-1:0] stk [8];
    phase_t           ph [8];
    int               depth;
    int               top;
    int               pos;
    bit               pre_mode;
    bit               post_mode;
    visit_t           walk_q[$];
    visit_t           v;
    pre_mode  = (shadow_order == ORD_PRE);
    post_mode = (shadow_order == ORD_POST);
    stk[0] = '0;
    ph[0]  = PH_LEFT;
    depth  = 1;
    while (depth > 0) begin
      top = depth - 1;
      pos = int'(stk[top]);
      case (ph[top])
        PH_LEFT: begin
          ph[top] = PH_RIGHT;
          if (pre_mode) walk_q.push_back(make_visit(pos));
          if (2 * pos + 1 < shadow_count) begin
            stk[depth] = POS_W'(2 * pos + 1);
            ph[depth]  = PH_LEFT;
            depth++;
          end
        end
        PH_RIGHT: begin
          ph[top] = PH_DONE;
          // the spare order code falls through to inorder
          if (!pre_mode && !post_mode) walk_q.push_back(make_visit(pos));
          if (2 * pos + 2 < shadow_count) begin
            stk[depth] = POS_W'(2 * pos + 2);
            ph[depth]  = PH_LEFT;
            depth++;
          end
        end
        default: begin
          if (post_mode) walk_q.push_back(make_visit(pos));
          depth--;
        end
      endcase
    end
    v = walk_q.pop_back();
    v.last = 1'b1;
    walk_q.push_back(v);
    foreach (walk_q[i]) pending_visits.push_back(walk_q[i]);
  endtask

  task automatic load_shadow(input logic [CHAR_W-1:0] ch, input logic last);
    // drop bytes once the store is full
    if (shadow_count < STORE_SIZE) begin
      shadow_store[shadow_count] = ch;
      shadow_count++;
    end
    if (last) begin
      predict_walk();
      shadow_count = 0;
    end
  endtask

  task automatic send_node(input logic [CHAR_W-1:0] ch, input logic last);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start     <= 1'b1;
    node_char <= ch;
    last_item <= last;
    do @(posedge clk); while (busy);
    load_shadow(ch, last);
    items_sent++;
  endtask

  task automatic send_tree(input int size);
    for (int i = 0; i < size; i++)
      send_node(8'($urandom_range(0, 255)), i == size - 1);
    trees_sent++;
  endtask

  // Drop start and hold until every predicted visit has come out.
  task automatic settle();
    @(negedge clk);
    start     <= 1'b0;
    last_item <= 1'b0;
    while (pending_visits.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_order(input logic [ORDER_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= value;
    shadow_order = value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_single_node();
    write_order(ORD_IN);
    send_node(8'hFF, 1'b1);
    trees_sent++;
    settle();
  endtask

  task automatic test_preorder();
    write_order(ORD_PRE);
    send_node(8'h00, 1'b0);
    send_node(8'h80, 1'b0);
    send_node(8'h7F, 1'b1);
    trees_sent++;
    settle();
  endtask

  task automatic test_postorder();
    write_order(ORD_POST);
    send_node(8'h55, 1'b0);
    send_node(8'hAA, 1'b1);
    trees_sent++;
    settle();
  endtask

  task automatic test_spare_order();
    write_order(ORD_SPARE);
    send_node(8'h01, 1'b0);
    send_node(8'hFE, 1'b1);
    trees_sent++;
    settle();
  endtask

  // The byte flagged last lands past the full store and must still start the walk.
  task automatic test_store_overflow();
    write_order(ORD_PRE);
    send_tree(STORE_SIZE + 1);
    settle();
  endtask

  task automatic test_random_trees();
    int size;
    int pick;
    while (items_sent < RANDOM_ITEMS) begin
      gaps_on = (items_sent < RANDOM_ITEMS - 50);
      // change order only in the idling part; the tail runs back to back
      if (gaps_on && $urandom_range(0, 1) == 0) begin
        settle();
        write_order(ORDER_W'($urandom_range(0, 3)));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) size = STORE_SIZE;
      else if (pick == 1) size = $urandom_range(STORE_SIZE + 1, STORE_SIZE + 4);
      else size = $urandom_range(1, STORE_SIZE);
      send_tree(size);
    end
    settle();
  endtask

  // Check each visit against the oldest prediction.
  always @(posedge clk) begin
    visit_t want;
    if (!rst && strobe === 1'b1) begin
      visits_seen++;
      if (pending_visits.size() == 0) begin
        report_mismatch($sformatf("unexpected visit pos %0d char %02h",
                                  node_position, out_char));
      end else begin
        want = pending_visits.pop_front();
        if (out_char !== want.ch)
          report_mismatch($sformatf("out_char %02h, want %02h", out_char, want.ch));
        if (node_position !== want.pos)
          report_mismatch($sformatf("node_position %0d, want %0d", node_position, want.pos));
        if (last_out !== want.last)
          report_mismatch($sformatf("last_out %b, want %b", last_out, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe === 1'b1 || cfg_write)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    node_char    = '0;
    last_item    = 1'b0;
    cfg_write    = 1'b0;
    cfg_wdata    = '0;
    shadow_count = 0;
    shadow_order = ORD_IN;
    err_count    = 0;
    items_sent   = 0;
    trees_sent   = 0;
    visits_seen  = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_node();
    test_preorder();
    test_postorder();
    test_spare_order();
    test_store_overflow();
    test_random_trees();

    repeat (10) @(negedge clk);
    if (pending_visits.size() != 0)
      report_mismatch($sformatf("%0d visits never came out", pending_visits.size()));
    $display("run: %0d bytes in %0d trees, %0d visits checked, %0d mismatches",
             items_sent, trees_sent, visits_seen, err_count);
    $display("run: all four order codes, trees of 1 to 16 nodes and store overflow");
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
